// ===== src/tct_pkg.sv =====
package tct_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [7:0] F_FIN = 8'h01;
   localparam logic [7:0] F_SYN = 8'h02;
   localparam logic [7:0] F_RST = 8'h04;
   localparam logic [7:0] F_ACK = 8'h10;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_SYN_SENT = 3'd1;
   localparam logic [2:0] PH_SYNACK   = 3'd2;
   localparam logic [2:0] PH_ESTAB    = 3'd3;
   localparam logic [2:0] PH_FIN_SENT = 3'd4;
   localparam logic [2:0] PH_FIN_ACK  = 3'd5;

   localparam logic [2:0] WHY_RULE    = 3'd0;
   localparam logic [2:0] WHY_NO_RULE = 3'd1;
   localparam logic [2:0] WHY_INVALID = 3'd2;
   localparam logic [2:0] WHY_EXISTS  = 3'd3;
   localparam logic [2:0] WHY_RESET   = 3'd4;
   localparam logic [2:0] WHY_FULL    = 3'd5;

   localparam logic [8:0] NO_RULE_CODE = 9'h1FF;

   // Entry word: client addr/port, server addr/port, phases, fin seqs, rule.
   typedef struct packed {
      logic [31:0] client_address;
      logic [15:0] cli_port;
      logic [31:0] server_address;
      logic [15:0] srv_port;
      logic [2:0]  client_phase;
      logic [2:0]  server_phase;
      logic [31:0] client_fin_seq;
      logic [31:0] server_fin_seq;
      logic [7:0]  entry_rule;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  flag_byte;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [7:0]  rule_index;
      logic        static_action;
      logic        static_no_rule;
   } req_type;

   typedef struct packed {
      logic       verdict;
      logic [2:0] why;
      logic [8:0] matched_rule;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;    // capture request, restart scan
      logic scan_read;   // issue read at scan index
      logic scan_check;  // check data returned for previous scan index
      logic finish;      // compute and commit the result
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_last_issued;
   } sts_type;

endpackage

// ===== src/tct_if.sv =====
interface tct_req_if;
   import tct_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tct_rsp_if;
   import tct_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/tct_ram.sv =====
module tct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/tct_datapath.sv =====
module tct_datapath
   import tct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_in,
   output sts_type sts,
   output rsp_type rsp_out
);
   req_type            req_ff;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   entry_type          hit_ff, hit_in;
   logic               free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry, rd_entry;
   rsp_type            rsp;
   logic               valid_clear, valid_set;

   tct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   assign sts.scan_last_issued = (rd_idx_ff == CNT_W'(TABLE_ENTRIES - 1));

   // Scan: read one entry per cycle, compare the previous one.
   always_comb begin
      logic fwd, rev;
      fwd = 1'b0;
      rev = 1'b0;
      rd_idx_in   = rd_idx_ff;
      chk_idx_in  = chk_idx_ff;
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      hit_in      = hit_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load_req) begin
         rd_idx_in  = '0;
         found_in   = 1'b0;
         free_ok_in = 1'b0;
      end else begin
         if (cmd.scan_read) begin
            rd_idx_in  = rd_idx_ff + CNT_W'(1);
            chk_idx_in = rd_idx_ff[IDX_W-1:0];
         end
         // Skip the first scan cycle: no read has come back for this item yet.
         if (cmd.scan_check && rd_idx_ff != '0) begin
            fwd = rd_entry.client_address == req_ff.src_addr &&
                  rd_entry.cli_port == req_ff.src_port &&
                  rd_entry.server_address == req_ff.dst_addr &&
                  rd_entry.srv_port == req_ff.dst_port;
            rev = rd_entry.server_address == req_ff.src_addr &&
                  rd_entry.srv_port == req_ff.src_port &&
                  rd_entry.client_address == req_ff.dst_addr &&
                  rd_entry.cli_port == req_ff.dst_port;
            if (valid_ff[chk_idx_ff] && (fwd || rev) && !found_ff) begin
               found_in   = 1'b1;
               hit_idx_in = chk_idx_ff;
               hit_in     = rd_entry;
            end
            if (!valid_ff[chk_idx_ff] && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end
      end
   end

   // Decision for the packet: open an entry on a bare SYN, else act on the matched entry.
   always_comb begin
      entry_type e;
      logic fin, bad, remove, srv_side;
      e           = hit_ff;
      fin         = (req_ff.flag_byte & F_FIN) != '0;
      bad         = 1'b0;
      remove      = 1'b0;
      srv_side    = hit_ff.server_address == req_ff.src_addr &&
                    hit_ff.srv_port == req_ff.src_port;
      wr_en       = 1'b0;
      wr_addr     = hit_idx_ff;
      valid_clear = 1'b0;
      valid_set   = 1'b0;
      rsp.verdict = 1'b1;
      rsp.why     = WHY_INVALID;
      rsp.matched_rule = NO_RULE_CODE;
      wr_entry    = hit_ff;
      if ((req_ff.flag_byte & F_ACK) == '0) begin
         if ((req_ff.flag_byte & F_SYN) == '0) begin
            rsp.why = WHY_INVALID;
         end else if (found_ff) begin
            rsp.why = WHY_EXISTS;
         end else if (!free_ok_ff) begin
            rsp.why = WHY_FULL;
         end else begin
            wr_en   = 1'b1;
            wr_addr = free_idx_ff;
            valid_set = 1'b1;
            wr_entry.client_address = req_ff.src_addr;
            wr_entry.cli_port       = req_ff.src_port;
            wr_entry.server_address = req_ff.dst_addr;
            wr_entry.srv_port       = req_ff.dst_port;
            wr_entry.client_phase   = PH_SYN_SENT;
            wr_entry.server_phase   = PH_IDLE;
            wr_entry.client_fin_seq = '0;
            wr_entry.server_fin_seq = '0;
            wr_entry.entry_rule     = req_ff.rule_index;
            rsp.verdict = req_ff.static_action;
            rsp.why     = req_ff.static_no_rule ? WHY_NO_RULE : WHY_RULE;
            rsp.matched_rule = {1'b0, req_ff.rule_index};
         end
      end else if (!found_ff) begin
         rsp.why = WHY_INVALID;
      end else if ((req_ff.flag_byte & F_RST) != '0) begin
         valid_clear = 1'b1;
         rsp.verdict = 1'b0;
         rsp.why     = WHY_RESET;
      end else begin
         if (srv_side) begin
            case (hit_ff.server_phase)
               PH_IDLE: e.server_phase = PH_SYNACK;
               PH_SYNACK: ;
               PH_ESTAB: begin
                  if (fin) begin
                     e.server_phase   = PH_FIN_SENT;
                     e.server_fin_seq = req_ff.seq_num;
                     if (hit_ff.client_phase == PH_FIN_SENT &&
                         req_ff.ack_num >= hit_ff.client_fin_seq)
                        e.client_phase = PH_FIN_ACK;
                  end
               end
               PH_FIN_SENT: begin
                  if (fin) e.server_fin_seq = req_ff.seq_num;
                  else if (hit_ff.client_phase == PH_FIN_SENT &&
                           hit_ff.client_fin_seq < req_ff.ack_num)
                     e.client_phase = PH_FIN_ACK;
               end
               PH_FIN_ACK: remove = 1'b1;
               default: bad = 1'b1;
            endcase
         end else begin
            case (hit_ff.client_phase)
               PH_SYN_SENT: begin
                  if (hit_ff.server_phase != PH_SYNACK) bad = 1'b1;
                  else begin
                     e.client_phase = PH_ESTAB;
                     e.server_phase = PH_ESTAB;
                  end
               end
               PH_ESTAB: begin
                  if (fin) begin
                     e.client_phase   = PH_FIN_SENT;
                     e.client_fin_seq = req_ff.seq_num;
                     if (hit_ff.server_phase == PH_FIN_SENT &&
                         req_ff.ack_num >= hit_ff.server_fin_seq)
                        e.server_phase = PH_FIN_ACK;
                  end
               end
               PH_FIN_SENT: begin
                  if (fin) e.client_fin_seq = req_ff.seq_num;
                  else if (hit_ff.server_phase == PH_FIN_SENT &&
                           hit_ff.server_fin_seq <= req_ff.ack_num)
                     e.server_phase = PH_FIN_ACK;
                  else bad = 1'b1;
               end
               PH_FIN_ACK: remove = 1'b1;
               default: bad = 1'b1;
            endcase
         end
         if (!bad) begin
            rsp.verdict      = 1'b0;
            rsp.why          = WHY_RULE;
            rsp.matched_rule = {1'b0, hit_ff.entry_rule};
            wr_en            = 1'b1;
            wr_entry         = e;
            valid_clear      = remove;
         end
      end
      wr_en = wr_en & cmd.finish;
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         if (valid_set) valid_in[free_idx_ff] = 1'b1;
         if (valid_clear) valid_in[hit_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_idx_ff <= '0;
         found_ff <= 1'b0;
         free_ok_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rd_idx_ff  <= rd_idx_in;
         found_ff   <= found_in;
         free_ok_ff <= free_ok_in;
      end
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ff      <= hit_in;
      free_idx_ff <= free_idx_in;
      if (cmd.load_req) req_ff <= req_in;
      if (cmd.finish) rsp_out <= rsp;
   end
endmodule

// ===== src/tct_control.sv =====
module tct_control
   import tct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_LAST  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Read the next entry; check the one read last cycle.
            cmd.scan_read  = 1'b1;
            cmd.scan_check = 1'b1;
            if (sts.scan_last_issued) state_in = ST_LAST;
         end
         ST_LAST: begin
            cmd.scan_check = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff) else $error("result lost");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> state_ff == ST_IDLE) else $error("load outside idle");
endmodule

// ===== src/tcp_connection_tracker.sv =====
// Channel | Dir | Payload
// req     | in  | TCP header fields, rule index, static decision
// rsp     | out | verdict, why, matched_rule
// One item at a time: accept, scan all TABLE_ENTRIES entries through one RAM
// read port (one per cycle), then decide and write back in ST_DONE once the
// output register is free.
// Reset (synchronous) clears the entry valid bits and the controller; entry
// payload lives in RAM and needs no clearing. A stalled rsp holds the result
// register; the next item is accepted while it waits.
module tcp_connection_tracker
   import tct_pkg::*;
(
   input logic clock,
   input logic reset,
   tct_req_if.sink   req,
   tct_rsp_if.source rsp
);
   cmd_type cmd;
   sts_type sts;

   tct_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tct_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_in  (req.payload),
      .sts     (sts),
      .rsp_out (rsp.payload)
   );
endmodule

// ===== test/tb_tcp_connection_tracker.sv =====
`timescale 1ns / 100ps

module tb_tcp_connection_tracker
   import tct_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;

   tct_req_if req ();
   tct_rsp_if rsp ();

   tcp_connection_tracker i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #5 clock = ~clock;

   // Row of the directed table: packet plus an optional typed-in answer.
   typedef struct {
      req_type pkt;
      logic    known;
      rsp_type answer;
   } row_type;

   // Shadow connection table.
   logic        conn_valid [TABLE_ENTRIES];
   entry_type   conn       [TABLE_ENTRIES];

   rsp_type     verdict_queue [$];
   int          fail_count;
   int          idle_cycles;
   bit          hold_rsp;
   bit          quiet_mode;

   // Small pool of endpoints so random packets hit tracked connections.
   logic [31:0] addr_pool [4];
   logic [15:0] port_pool [4];

   // Locate a connection in either direction, lowest slot first.
   function automatic int lookup_conn(req_type p);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (conn_valid[i]) begin
            if (conn[i].client_address == p.src_addr && conn[i].cli_port == p.src_port &&
                conn[i].server_address == p.dst_addr && conn[i].srv_port == p.dst_port)
               return i;
            if (conn[i].server_address == p.src_addr && conn[i].srv_port == p.src_port &&
                conn[i].client_address == p.dst_addr && conn[i].cli_port == p.dst_port)
               return i;
         end
      end
      return -1;
   endfunction

   // Advance the shadow table by one packet and return its verdict.
   function automatic rsp_type track_packet(req_type p);
      rsp_type   r;
      int        e;
      logic      fin;
      logic      bad;
      logic      remove;
      entry_type c;
      fin = p.flag_byte[0];
      r = '{verdict: 1'b1, why: WHY_INVALID, matched_rule: NO_RULE_CODE};
      bad = 1'b0;
      remove = 1'b0;
      if ((p.flag_byte & F_ACK) == 0) begin
         if ((p.flag_byte & F_SYN) == 0) return r;
         if (lookup_conn(p) >= 0) begin
            r.why = WHY_EXISTS;
            return r;
         end
         e = -1;
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!conn_valid[i] && e < 0) e = i;
         if (e < 0) begin
            r.why = WHY_FULL;
            return r;
         end
         conn_valid[e] = 1'b1;
         conn[e] = '{client_address: p.src_addr, cli_port: p.src_port,
                     server_address: p.dst_addr, srv_port: p.dst_port,
                     client_phase: PH_SYN_SENT, server_phase: PH_IDLE,
                     client_fin_seq: '0, server_fin_seq: '0, entry_rule: p.rule_index};
         r.verdict = p.static_action;
         r.why = p.static_no_rule ? WHY_NO_RULE : WHY_RULE;
         r.matched_rule = {1'b0, p.rule_index};
         return r;
      end
      e = lookup_conn(p);
      if (e < 0) return r;
      if ((p.flag_byte & F_RST) != 0) begin
         conn_valid[e] = 1'b0;
         r.verdict = 1'b0;
         r.why = WHY_RESET;
         return r;
      end
      c = conn[e];
      // A packet matching both endpoints counts as server side.
      if (c.server_address == p.src_addr && c.srv_port == p.src_port) begin
         case (c.server_phase)
            PH_IDLE:   c.server_phase = PH_SYNACK;
            PH_SYNACK: ;
            PH_ESTAB:
               if (fin) begin
                  c.server_phase = PH_FIN_SENT;
                  c.server_fin_seq = p.seq_num;
                  if (c.client_phase == PH_FIN_SENT && p.ack_num >= c.client_fin_seq)
                     c.client_phase = PH_FIN_ACK;
               end
            PH_FIN_SENT:
               if (fin) c.server_fin_seq = p.seq_num;
               else if (c.client_phase == PH_FIN_SENT && c.client_fin_seq < p.ack_num)
                  c.client_phase = PH_FIN_ACK;
            PH_FIN_ACK: remove = 1'b1;
            default:    bad = 1'b1;
         endcase
      end else begin
         case (c.client_phase)
            PH_SYN_SENT:
               if (c.server_phase != PH_SYNACK) bad = 1'b1;
               else begin
                  c.client_phase = PH_ESTAB;
                  c.server_phase = PH_ESTAB;
               end
            PH_ESTAB:
               if (fin) begin
                  c.client_phase = PH_FIN_SENT;
                  c.client_fin_seq = p.seq_num;
                  if (c.server_phase == PH_FIN_SENT && p.ack_num >= c.server_fin_seq)
                     c.server_phase = PH_FIN_ACK;
               end
            PH_FIN_SENT:
               if (fin) c.client_fin_seq = p.seq_num;
               else if (c.server_phase == PH_FIN_SENT && c.server_fin_seq <= p.ack_num)
                  c.server_phase = PH_FIN_ACK;
               else bad = 1'b1;
            PH_FIN_ACK: remove = 1'b1;
            default:    bad = 1'b1;
         endcase
      end
      if (bad) return r;
      conn[e] = c;
      if (remove) conn_valid[e] = 1'b0;
      r = '{verdict: 1'b0, why: WHY_RULE, matched_rule: {1'b0, c.entry_rule}};
      return r;
   endfunction

   function automatic req_type make_pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                        logic [15:0] dp, logic [7:0] fl, logic [31:0] sq,
                                        logic [31:0] ak, logic [7:0] ri, logic sa_bit,
                                        logic nr_bit);
      req_type p;
      p = '{src_addr: sa, dst_addr: da, src_port: sp, dst_port: dp, flag_byte: fl,
            seq_num: sq, ack_num: ak, rule_index: ri, static_action: sa_bit,
            static_no_rule: nr_bit};
      return p;
   endfunction

   // Offer one item, with random idle gaps unless quiet, and hold until accepted.
   // Valid stays high after acceptance; the next call or the caller drops it.
   task automatic send_pkt(req_type p, logic known, rsp_type answer);
      rsp_type want;
      while (!quiet_mode && $urandom_range(99) < 8) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= p;
      do @(posedge clock); while (!req.ready);
      want = track_packet(p);
      if (known && want != answer) begin
         $error("table row disagrees: expected %h got %h", answer, want);
         fail_count++;
      end
      verdict_queue.push_back(want);
   endtask

   // Random packet: mostly connections from the pool walking through their lifecycle.
   function automatic req_type random_pkt();
      req_type     p;
      int          a, b;
      logic [7:0]  fl;
      logic [31:0] sq;
      a = $urandom_range(3);
      b = $urandom_range(3);
      case ($urandom_range(9))
         0: fl = F_SYN;
         1: fl = F_SYN | F_ACK;
         2, 3: fl = F_ACK;
         4, 5: fl = F_ACK | F_FIN;
         6: fl = F_ACK | F_RST;
         7: fl = 8'($urandom_range(255));
         default: fl = F_ACK | ($urandom_range(1) ? F_FIN : 8'h00);
      endcase
      sq = $urandom_range(15);
      p = make_pkt(addr_pool[a], addr_pool[b], port_pool[$urandom_range(3)],
                   port_pool[$urandom_range(3)], fl, sq, $urandom_range(15),
                   8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      if ($urandom_range(19) == 0) begin
         // Noise over the whole field range.
         p.src_addr = $urandom;
         p.dst_addr = $urandom;
         p.src_port = 16'($urandom);
         p.dst_port = 16'($urandom);
         p.seq_num  = $urandom;
         p.ack_num  = $urandom;
      end
      return p;
   endfunction

   // Receiver: random back-pressure, or a long hold-off when asked.
   initial begin
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 8);
         @(posedge clock);
      end
   end

   // Compare every accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (verdict_queue.size() == 0) begin
            $error("result with no prediction waiting: %h", rsp.payload);
            fail_count++;
         end else begin
            rsp_type want;
            want = verdict_queue.pop_front();
            if (rsp.payload.verdict !== want.verdict) begin
               $error("verdict: expected %0d got %0d", want.verdict, rsp.payload.verdict);
               fail_count++;
            end
            if (rsp.payload.why !== want.why) begin
               $error("why: expected %0d got %0d", want.why, rsp.payload.why);
               fail_count++;
            end
            if (rsp.payload.matched_rule !== want.matched_rule) begin
               $error("matched_rule: expected %h got %h", want.matched_rule,
                      rsp.payload.matched_rule);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles without any handshake.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      row_type     rows [$];
      logic [31:0] ca, sa;
      logic [15:0] cp, sp;
      rsp_type     none;
      fail_count = 0;
      idle_cycles = 0;
      hold_rsp = 1'b0;
      quiet_mode = 1'b0;
      req.valid <= 1'b0;
      req.payload <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         conn_valid[i] = 1'b0;
         conn[i] = '0;
      end
      addr_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0102};
      port_pool = '{16'h0000, 16'hFFFF, 16'd80, 16'd443};
      none = '{verdict: 1'b1, why: WHY_INVALID, matched_rule: NO_RULE_CODE};
      ca = 32'hFFFF_FFFF; sa = 32'h0000_0000; cp = 16'hFFFF; sp = 16'h0000;

      // Directed table: answers typed only for error codes, resets and openings.
      rows.push_back('{make_pkt(ca, sa, cp, sp, 8'h00, 0, 0, 0, 0, 0), 1, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK, 0, 0, 0, 0, 0), 1, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_SYN, 0, 0, 8'hFF, 1, 1), 1,
                       '{1'b1, WHY_NO_RULE, 9'h0FF}});
      rows.push_back('{make_pkt(sa, ca, sp, cp, F_SYN, 0, 0, 0, 0, 0), 1,
                       '{1'b1, WHY_EXISTS, NO_RULE_CODE}});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK, 0, 0, 0, 0, 0), 1, none});
      rows.push_back('{make_pkt(sa, ca, sp, cp, F_SYN | F_ACK, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_pkt(sa, ca, sp, cp, F_ACK, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK, 5, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK | F_FIN, 32'hFFFF_FFFF, 0, 0, 0, 0),
                       0, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK, 0, 0, 0, 0, 0), 1, none});
      rows.push_back('{make_pkt(sa, ca, sp, cp, F_ACK | F_FIN, 7, 32'hFFFF_FFFF, 0, 0, 0),
                       0, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK, 0, 7, 0, 0, 0), 0, none});
      rows.push_back('{make_pkt(sa, ca, sp, cp, F_ACK, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_pkt(ca, sa, cp, sp, F_ACK, 0, 0, 0, 0, 0), 1, none});
      // Self connection, then a reset of it.
      rows.push_back('{make_pkt(sa, sa, sp, sp, F_SYN, 0, 0, 8'h00, 0, 0), 1,
                       '{1'b0, WHY_RULE, 9'h000}});
      rows.push_back('{make_pkt(sa, sa, sp, sp, F_ACK, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{make_pkt(sa, sa, sp, sp, F_ACK | F_RST, 0, 0, 0, 0, 0), 1,
                       '{1'b0, WHY_RESET, NO_RULE_CODE}});
      rows.push_back('{make_pkt(ca, sa, cp, sp, 8'hEF, 0, 0, 0, 0, 0), 0, none});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_pkt(rows[i].pkt, rows[i].known, rows[i].answer);

      // Fill the table to its limit, then one more SYN reports full.
      for (int i = 0; i < TABLE_ENTRIES + 1; i++) begin
         req_type p;
         p = make_pkt(32'h1000_0000 + i, 32'h2000_0000, 16'd1000, 16'd22, F_SYN, 0, 0,
                      8'(i), i[0], i[1]);
         send_pkt(p, 1'b0, none);
      end
      // Drop them by RST so the random part starts with an empty table.
      for (int i = 0; i < TABLE_ENTRIES; i++)
         send_pkt(make_pkt(32'h2000_0000, 32'h1000_0000 + i, 16'd22, 16'd1000,
                           F_ACK | F_RST, 0, 0, 0, 0, 0), 1'b0, none);
      req.valid <= 1'b0;

      // Pause the sender until the block drains.
      wait (verdict_queue.size() == 0);

      for (int n = 0; n < 1650; n++) begin
         if (n == 300) hold_rsp = 1'b1;
         quiet_mode = (n >= 900 && n < 1100);
         send_pkt(random_pkt(), 1'b0, none);
      end
      req.valid <= 1'b0;
      quiet_mode = 1'b0;

      wait (verdict_queue.size() == 0);
      repeat (TABLE_ENTRIES + 10) @(posedge clock);
      if (fail_count == 0 && verdict_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
